// File: hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, ignored while reset is held.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, ignored while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hw/rtl/ciopfb_pkg.sv
package ciopfb_pkg;

    // Access kinds carried in tuser.
    typedef enum logic [1:0] {
        KIND_RD_PORT = 2'd0,
        KIND_RD_DIR  = 2'd1,
        KIND_WR_PORT = 2'd2,
        KIND_WR_DIR  = 2'd3
    } t_kind;

    // Configuration register indexes.
    localparam logic CFG_BIT3_HOLD  = 1'b0;
    localparam logic CFG_BIT67_HOLD = 1'b1;

    localparam int unsigned HOLD_W = 24;
    localparam logic [HOLD_W-1:0] HOLD3_RESET  = 24'd985248;
    localparam logic [HOLD_W-1:0] HOLD67_RESET = 24'd360000;

    // Input levels of the undriven pins, and the motor control bit.
    localparam logic [7:0] PULLUP_BITS    = 8'h07;
    localparam logic [7:0] TAPE_SENSE_BIT = 8'h10;
    localparam logic [7:0] MOTOR_BIT      = 8'h20;

    localparam int unsigned RESULT_W = 21;
    localparam int unsigned OUT_TDATA_W = 24;

    // Fixed-width fields of an accepted input word (the cycle count travels apart).
    typedef struct packed {
        t_kind      kind;
        logic [7:0] write_data;
        logic       play_key;
        logic [7:0] vic_last_byte;
    } t_in_ctl;

    // One result word.
    typedef struct packed {
        logic [7:0] read_data;
        logic       motor_update;
        logic       motor_on;
        logic       ram_write;
        logic       ram_write_addr;
        logic [7:0] ram_write_data;
        logic       bank_update;
    } t_result;

endpackage

// File: hw/rtl/cpu_io_port_with_floating_bits.sv
// Channel   Direction  Handshake                       Payload
// s_axis    in         s_axis_tvalid / s_axis_tready   tdata: access fields, tuser: kind
// m_axis    out        m_axis_tvalid / m_axis_tready   tdata: result fields
// cfg       in         i_cfg_we (no wait)              i_cfg_addr, i_cfg_wdata
//
// One word is accepted every cycle unless the output stalls; the port logic sits
// between the input register and the result register, which offers the result.
// Reset is synchronous and active low; it clears the port, direction and
// deadline registers and loads the default hold times.
// A stall on the output backs up through the result and input registers,
// so tready falls only once both hold a word.
`include "assert_macros.svh"

module cpu_io_port_with_floating_bits
    import ciopfb_pkg::*;
#(
    parameter int unsigned CYCLE_WIDTH = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // write_data[7:0], cycle_now[CYCLE_WIDTH+7:8], play_key, vic_last_byte, zero fill
    input  logic [((CYCLE_WIDTH + 17 + 7) / 8) * 8 - 1:0] s_axis_tdata,
    // kind[1:0]
    input  logic [1:0]             s_axis_tuser,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // read_data[7:0], motor_update, motor_on, ram_write, ram_write_addr,
    // ram_write_data[19:12], bank_update, zero fill
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [HOLD_W-1:0]      i_cfg_wdata
);

    localparam int unsigned InTdataW = ((CYCLE_WIDTH + 17 + 7) / 8) * 8;

    logic                   w_in_valid;
    t_in_ctl                w_ctl;
    logic [CYCLE_WIDTH-1:0] w_cycle;
    logic                   w_out_free;
    logic                   w_advance;
    t_result                w_result;

    // A word moves from the input register into the result register.
    assign w_advance = w_in_valid && w_out_free;

    ciopfb_in_stage #(
        .CYCLE_WIDTH (CYCLE_WIDTH),
        .TDATA_W     (InTdataW)
    ) u_in (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .i_advance     (w_advance),
        .o_valid       (w_in_valid),
        .o_ctl         (w_ctl),
        .o_cycle       (w_cycle)
    );

    ciopfb_core #(
        .CYCLE_WIDTH (CYCLE_WIDTH)
    ) u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_advance   (w_advance),
        .i_ctl       (w_ctl),
        .i_cycle     (w_cycle),
        .o_result    (w_result)
    );

    ciopfb_out_stage u_out (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_advance     (w_advance),
        .i_result      (w_result),
        .o_free        (w_out_free),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    `ASSERT_NEXT(a_adv_gives_out, i_clk, i_rst_n, w_advance, m_axis_tvalid)
    `ASSERT_SAME(a_adv_needs_room, i_clk, i_rst_n, w_advance, !m_axis_tvalid || m_axis_tready)
    `ASSERT_NEXT(a_idle_keeps_in, i_clk, i_rst_n, w_in_valid && !w_out_free, w_in_valid)

endmodule

// File: hw/rtl/ciopfb_in_stage.sv
module ciopfb_in_stage
    import ciopfb_pkg::*;
#(
    parameter int unsigned CYCLE_WIDTH = 48,
    parameter int unsigned TDATA_W     = ((CYCLE_WIDTH + 17 + 7) / 8) * 8
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [TDATA_W-1:0]     s_axis_tdata,
    input  logic [1:0]             s_axis_tuser,
    input  logic                   i_advance,
    output logic                   o_valid,
    output t_in_ctl                o_ctl,
    output logic [CYCLE_WIDTH-1:0] o_cycle
);

    logic                   r_valid;
    logic                   n_valid;
    t_in_ctl                r_ctl;
    logic [CYCLE_WIDTH-1:0] r_cycle;
    logic                   w_take;

    // The register is free when empty or when its word moves on this cycle.
    assign s_axis_tready = !r_valid || i_advance;
    assign w_take        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        if (w_take) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Unpack the word into its fields.
    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_ctl.kind          <= t_kind'(s_axis_tuser);
            r_ctl.write_data    <= s_axis_tdata[7:0];
            r_cycle             <= s_axis_tdata[8 +: CYCLE_WIDTH];
            r_ctl.play_key      <= s_axis_tdata[8 + CYCLE_WIDTH];
            r_ctl.vic_last_byte <= s_axis_tdata[9 + CYCLE_WIDTH +: 8];
        end
    end

    assign o_valid = r_valid;
    assign o_ctl   = r_ctl;
    assign o_cycle = r_cycle;

endmodule

// File: hw/rtl/ciopfb_core.sv
`include "assert_macros.svh"

module ciopfb_core
    import ciopfb_pkg::*;
#(
    parameter int unsigned CYCLE_WIDTH = 48
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_we,
    input  logic                   i_cfg_addr,
    input  logic [HOLD_W-1:0]      i_cfg_wdata,
    input  logic                   i_advance,
    input  t_in_ctl                i_ctl,
    input  logic [CYCLE_WIDTH-1:0] i_cycle,
    output t_result                o_result
);

    logic [HOLD_W-1:0]      r_hold3;
    logic [HOLD_W-1:0]      r_hold67;
    logic [7:0]             r_port_value;
    logic [7:0]             r_direction_value;
    logic [CYCLE_WIDTH-1:0] r_bit3_deadline;
    logic [CYCLE_WIDTH-1:0] r_bit6_deadline;
    logic [CYCLE_WIDTH-1:0] r_bit7_deadline;
    logic [CYCLE_WIDTH-1:0] n_bit3_deadline;
    logic [CYCLE_WIDTH-1:0] n_bit6_deadline;
    logic [CYCLE_WIDTH-1:0] n_bit7_deadline;
    logic [CYCLE_WIDTH-1:0] w_due3;
    logic [CYCLE_WIDTH-1:0] w_due67;
    logic [7:0]             w_levels;
    logic                   w_wr_port;
    logic                   w_wr_dir;

    // New deadline of one capacitive bit on a direction write.
    function automatic logic [CYCLE_WIDTH-1:0] f_float(
        input logic [CYCLE_WIDTH-1:0] deadline,
        input logic                   old_dir,
        input logic                   new_dir,
        input logic                   port_bit,
        input logic [CYCLE_WIDTH-1:0] due
    );
        logic [CYCLE_WIDTH-1:0] v;
        v = deadline;
        if (new_dir) begin
            v = '0;
        end
        if (old_dir && !new_dir && port_bit) begin
            v = due;
        end
        return v;
    endfunction

    assign w_wr_port = i_advance && (i_ctl.kind == KIND_WR_PORT);
    assign w_wr_dir  = i_advance && (i_ctl.kind == KIND_WR_DIR);

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hold3  <= HOLD3_RESET;
            r_hold67 <= HOLD67_RESET;
        end else if (i_cfg_we) begin
            if (i_cfg_addr == CFG_BIT3_HOLD) begin
                r_hold3 <= i_cfg_wdata;
            end else begin
                r_hold67 <= i_cfg_wdata;
            end
        end
    end

    // Discharge deadlines: the sum wraps at the cycle width.
    assign w_due3  = i_cycle + CYCLE_WIDTH'(r_hold3);
    assign w_due67 = i_cycle + CYCLE_WIDTH'(r_hold67);

    always_comb begin
        n_bit3_deadline = f_float(r_bit3_deadline, r_direction_value[3],
                                  i_ctl.write_data[3], r_port_value[3], w_due3);
        n_bit6_deadline = f_float(r_bit6_deadline, r_direction_value[6],
                                  i_ctl.write_data[6], r_port_value[6], w_due67);
        n_bit7_deadline = f_float(r_bit7_deadline, r_direction_value[7],
                                  i_ctl.write_data[7], r_port_value[7], w_due67);
    end

    // Port state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_port_value      <= '0;
            r_direction_value <= '0;
            r_bit3_deadline   <= '0;
            r_bit6_deadline   <= '0;
            r_bit7_deadline   <= '0;
        end else begin
            if (w_wr_port) begin
                r_port_value <= i_ctl.write_data;
            end
            if (w_wr_dir) begin
                r_direction_value <= i_ctl.write_data;
                r_bit3_deadline   <= n_bit3_deadline;
                r_bit6_deadline   <= n_bit6_deadline;
                r_bit7_deadline   <= n_bit7_deadline;
            end
        end
    end

    // Levels seen on the pins that are inputs.
    always_comb begin
        w_levels    = PULLUP_BITS;
        w_levels[3] = r_bit3_deadline > i_cycle;
        w_levels[6] = r_bit6_deadline > i_cycle;
        w_levels[7] = r_bit7_deadline > i_cycle;
        if (!i_ctl.play_key) begin
            w_levels = w_levels | TAPE_SENSE_BIT;
        end
    end

    // Result of the access.
    always_comb begin
        o_result = '0;
        case (i_ctl.kind)
            KIND_RD_PORT: begin
                o_result.read_data = (r_port_value & r_direction_value)
                                   | (w_levels & ~r_direction_value);
            end
            KIND_RD_DIR: begin
                o_result.read_data = r_direction_value;
            end
            KIND_WR_PORT: begin
                if ((r_direction_value & MOTOR_BIT) != 8'h00) begin
                    o_result.motor_update = 1'b1;
                    o_result.motor_on     = (i_ctl.write_data & MOTOR_BIT) == 8'h00;
                end
                o_result.ram_write      = 1'b1;
                o_result.ram_write_addr = 1'b1;
                o_result.ram_write_data = i_ctl.vic_last_byte;
                o_result.bank_update    = 1'b1;
            end
            KIND_WR_DIR: begin
                o_result.ram_write      = 1'b1;
                o_result.ram_write_addr = 1'b0;
                o_result.ram_write_data = i_ctl.vic_last_byte;
                o_result.bank_update    = 1'b1;
            end
            default: begin
                o_result = '0;
            end
        endcase
    end

    `ASSERT_NEXT(a_dir_written, i_clk, i_rst_n, w_wr_dir, r_direction_value == $past(i_ctl.write_data))
    `ASSERT_NEXT(a_out_clears_b3, i_clk, i_rst_n, w_wr_dir && i_ctl.write_data[3], r_bit3_deadline == '0)
    `ASSERT_NEXT(a_port_holds, i_clk, i_rst_n, !w_wr_port, $stable(r_port_value))

endmodule

// File: hw/rtl/ciopfb_out_stage.sv
module ciopfb_out_stage
    import ciopfb_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_advance,
    input  t_result                i_result,
    output logic                   o_free,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // The result register takes a new word when empty or being emptied.
    assign o_free = !r_valid || m_axis_tready;

    always_comb begin
        if (i_advance) begin
            n_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_valid = 1'b0;
        end else begin
            n_valid = r_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_advance) begin
            r_result <= i_result;
        end
    end

    // Pack from the lowest bit up, zero filled to whole bytes.
    assign m_axis_tvalid = r_valid;
    assign m_axis_tdata  = {
        (OUT_TDATA_W - RESULT_W)'(0),
        r_result.bank_update,
        r_result.ram_write_data,
        r_result.ram_write_addr,
        r_result.ram_write,
        r_result.motor_on,
        r_result.motor_update,
        r_result.read_data
    };

endmodule
